>>> sv/assert_macros.svh
// Assertion macros shared by the RTL files of the command line tokenizer.
// No dependencies; synthesis builds define SYNTHESIS and get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/icl_pkg.sv
// Package for the inline command line tokenizer: sizes, character codes,
// event codes and the state and result structs. No dependencies.
package icl_pkg;

    localparam int BUF_DEPTH  = 256;
    localparam int MAX_ARGS   = 16;
    localparam int IDX_W      = $clog2(BUF_DEPTH + 1);
    localparam int ARG_W      = $clog2(MAX_ARGS + 2);
    localparam int CFG_SIZE_W = 9;
    localparam int CFG_ARGS_W = 5;
    localparam int CFG_DATA_W = 9;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam logic CFG_IDX_SIZE = 1'b0;
    localparam logic CFG_IDX_ARGS = 1'b1;

    typedef enum logic [3:0] {
        EV_IGNORED      = 4'd0,
        EV_STORED       = 4'd1,
        EV_FULL         = 4'd2,
        EV_SEP          = 4'd3,
        EV_SEP_UNSTORED = 4'd4,
        EV_EXTRA_SPACE  = 4'd5,
        EV_EMPTY        = 4'd6,
        EV_DONE         = 4'd7,
        EV_SYNTAX       = 4'd8,
        EV_ARGS         = 4'd9,
        EV_OVERFLOW     = 4'd10
    } t_event;

    typedef struct packed {
        logic              collecting;
        logic [IDX_W-1:0]  fill_index;
        logic [ARG_W-1:0]  token_count;
        logic [IDX_W-1:0]  token_start;
    } t_state;

    typedef struct packed {
        t_event            event_res;
        logic [IDX_W-1:0]  position;
        logic [7:0]        data_byte;
        logic [ARG_W-1:0]  arg_count;
    } t_result;

endpackage

>>> sv/inline_command_line_tokenizer.sv
// Top level of the inline command line tokenizer: input register, line state,
// config registers and result register. Depends on icl_pkg, icl_step, assert_macros.svh.
//
//   channel   direction  handshake                   payload
//   in        sink       i_in_valid / o_in_ready     i_in_byte
//   out       source     o_out_valid / i_out_ready   o_event_res, o_position,
//                                                    o_data_byte, o_arg_count
//   cfg       sink       i_cfg_we (no ready)         i_cfg_index, i_cfg_data
//
// One beat per cycle sustained while the output is not stalled; a byte's event
// passes through the input register and then the result register.
// The step logic between them is a handful of compares and 9-bit adds.
// Reset (synchronous, active low) returns to idle with buffer_size 256 and
// max_args 16. A stalled output holds the result register and the line state;
// the input register still takes one more beat while the result waits.
`include "assert_macros.svh"

module inline_command_line_tokenizer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [7:0]                        i_in_byte,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [3:0]                        o_event_res,
    output logic [8:0]                        o_position,
    output logic [7:0]                        o_data_byte,
    output logic [4:0]                        o_arg_count,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_index,
    input  logic [icl_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    logic                               r_in_valid;
    logic [7:0]                         r_in_byte;
    icl_pkg::t_state                    r_state;
    icl_pkg::t_state                    n_state;
    logic                               r_out_valid;
    icl_pkg::t_result                   r_out;
    icl_pkg::t_result                   n_out;
    logic [icl_pkg::CFG_SIZE_W-1:0]     r_buffer_size;
    logic [icl_pkg::CFG_ARGS_W-1:0]     r_max_args;
    logic                               advance;

    // Advance the held byte whenever the result register is empty or draining.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // Config writes land directly; the user must write only while idle, the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_size <= icl_pkg::CFG_SIZE_W'(256);
            r_max_args    <= icl_pkg::CFG_ARGS_W'(16);
        end else if (i_cfg_we) begin
            if (i_cfg_index == icl_pkg::CFG_IDX_SIZE) begin
                r_buffer_size <= i_cfg_data[icl_pkg::CFG_SIZE_W-1:0];
            end else if (i_cfg_index == icl_pkg::CFG_IDX_ARGS) begin
                r_max_args <= i_cfg_data[icl_pkg::CFG_ARGS_W-1:0];
            end
        end
    end

    // Input register: hold the byte until the step logic consumes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
        end
    end

    icl_step u_step (
        .i_state       (r_state),
        .i_byte        (r_in_byte),
        .i_buffer_size (r_buffer_size),
        .i_max_args    (r_max_args),
        .o_state       (n_state),
        .o_result      (n_out)
    );

    // Line state moves only together with a new result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register: load on advance, drop valid once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_event_res = r_out.event_res;
    assign o_position  = r_out.position;
    assign o_data_byte = r_out.data_byte;
    assign o_arg_count = r_out.arg_count;

    // Idle always means an empty line.
    `ASSERT_IMPLIES(a_idle_clean, i_clk, i_rst_n, !r_state.collecting, (r_state.fill_index == '0) && (r_state.token_count == '0) && (r_state.token_start == '0))
    // Count saturates one above the limit; fill never passes the depth.
    `ASSERT_ALWAYS(a_bounds, i_clk, i_rst_n, (32'(r_state.token_count) <= icl_pkg::MAX_ARGS + 1) && (32'(r_state.fill_index) <= icl_pkg::BUF_DEPTH))
    // A pending line end leaves the state idle.
    `ASSERT_IMPLIES(a_end_idle, i_clk, i_rst_n, r_out_valid && (r_out.event_res == icl_pkg::EV_DONE || r_out.event_res == icl_pkg::EV_ARGS || r_out.event_res == icl_pkg::EV_OVERFLOW), !r_state.collecting)
    // A stored byte or separator was written below the fill index.
    `ASSERT_IMPLIES(a_store_pos, i_clk, i_rst_n, r_out_valid && (r_out.event_res == icl_pkg::EV_STORED || r_out.event_res == icl_pkg::EV_SEP), r_out.position < r_state.fill_index)

endmodule

>>> sv/icl_step.sv
// Per-byte tokenizer step: next line state and the event for one byte.
// Depends on icl_pkg.
module icl_step (
    input  icl_pkg::t_state                  i_state,
    input  logic [7:0]                       i_byte,
    input  logic [icl_pkg::CFG_SIZE_W-1:0]   i_buffer_size,
    input  logic [icl_pkg::CFG_ARGS_W-1:0]   i_max_args,
    output icl_pkg::t_state                  o_state,
    output icl_pkg::t_result                 o_result
);

    logic [icl_pkg::IDX_W-1:0] size_cap;
    logic [icl_pkg::ARG_W-1:0] args_cap;
    logic [icl_pkg::ARG_W-1:0] count_inc;
    logic                      is_prefix;
    logic                      is_eol;
    logic                      is_space;
    logic                      token_empty;
    logic                      has_room;

    assign size_cap = (32'(i_buffer_size) > icl_pkg::BUF_DEPTH)
                    ? icl_pkg::IDX_W'(icl_pkg::BUF_DEPTH)
                    : icl_pkg::IDX_W'(i_buffer_size);
    assign args_cap = (32'(i_max_args) > icl_pkg::MAX_ARGS)
                    ? icl_pkg::ARG_W'(icl_pkg::MAX_ARGS)
                    : icl_pkg::ARG_W'(i_max_args);
    // Saturate at one above the limit.
    assign count_inc = (32'(i_state.token_count) < icl_pkg::MAX_ARGS + 1)
                     ? i_state.token_count + icl_pkg::ARG_W'(1)
                     : i_state.token_count;
    assign token_empty = (i_state.token_start == i_state.fill_index);
    assign has_room    = (i_state.fill_index < size_cap);

    always_comb begin
        is_eol    = (i_byte inside {icl_pkg::CH_CR, icl_pkg::CH_LF});
        is_space  = (i_byte == icl_pkg::CH_SPACE);
        is_prefix = (i_byte inside {icl_pkg::CH_PLUS, icl_pkg::CH_MINUS, icl_pkg::CH_COLON,
                                    icl_pkg::CH_DOLLAR, icl_pkg::CH_STAR});
    end

    always_comb begin
        logic [icl_pkg::IDX_W-1:0] end_fill;
        logic [icl_pkg::ARG_W-1:0] end_count;
        o_state             = i_state;
        o_result.event_res  = icl_pkg::EV_IGNORED;
        o_result.position   = '0;
        o_result.data_byte  = '0;
        o_result.arg_count  = i_state.token_count;
        end_fill            = token_empty ? i_state.fill_index - icl_pkg::IDX_W'(1)
                                          : i_state.fill_index;
        end_count           = token_empty ? i_state.token_count : count_inc;
        if (!i_state.collecting && (is_prefix || is_eol)) begin
            o_result.event_res = icl_pkg::EV_IGNORED;
        end else if (!i_state.collecting && i_state.fill_index != '0) begin
            o_result.event_res = icl_pkg::EV_SYNTAX;
            o_state            = '0;
        end else if (is_eol) begin
            o_state = '0;
            if (i_state.fill_index == '0) begin
                o_result.event_res = icl_pkg::EV_EMPTY;
            end else begin
                o_result.arg_count = end_count;
                if (end_count > args_cap) begin
                    o_result.event_res = icl_pkg::EV_ARGS;
                end else if (end_fill >= size_cap) begin
                    o_result.event_res = icl_pkg::EV_OVERFLOW;
                end else begin
                    o_result.event_res = icl_pkg::EV_DONE;
                    o_result.position  = end_fill;
                end
            end
        end else if (is_space) begin
            o_state.collecting = 1'b1;
            if (token_empty) begin
                o_result.event_res = icl_pkg::EV_EXTRA_SPACE;
            end else begin
                o_state.token_count = count_inc;
                o_result.arg_count  = count_inc;
                if (has_room) begin
                    o_result.event_res = icl_pkg::EV_SEP;
                    o_result.position  = i_state.fill_index;
                    o_state.fill_index = i_state.fill_index + icl_pkg::IDX_W'(1);
                    o_state.token_start = i_state.fill_index + icl_pkg::IDX_W'(1);
                end else begin
                    o_result.event_res  = icl_pkg::EV_SEP_UNSTORED;
                    o_state.token_start = i_state.fill_index;
                end
            end
        end else begin
            o_state.collecting = 1'b1;
            if (has_room) begin
                o_result.event_res = icl_pkg::EV_STORED;
                o_result.position  = i_state.fill_index;
                o_result.data_byte = i_byte;
                o_state.fill_index = i_state.fill_index + icl_pkg::IDX_W'(1);
            end else begin
                o_result.event_res = icl_pkg::EV_FULL;
            end
        end
    end

endmodule

>>> tb/sv/icl_tokenizer_monitor.sv
`timescale 1ns / 1ps
// Line tokenizer monitor: watches the byte, event and register ports of the
// tokenizer, predicts each event and compares it. Depends on icl_pkg.
module icl_tokenizer_monitor
    import icl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [7:0]            i_in_byte,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [3:0]            i_event_res,
    input  logic [8:0]            i_position,
    input  logic [7:0]            i_data_byte,
    input  logic [4:0]            i_arg_count,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    // predicted line state and register copies
    logic    line_active;
    int      fill_pos;
    int      tokens;
    int      token_base;
    int      buf_size_reg;
    int      max_args_reg;
    int      fails = 0;
    t_result line_events[$];
    t_result want_ev;

    function automatic void clear_line();
        line_active = 1'b0;
        fill_pos    = 0;
        tokens      = 0;
        token_base  = 0;
    endfunction

    // count saturates one above the largest legal argument count
    function automatic void bump_tokens();
        if (tokens < MAX_ARGS + 1)
            tokens++;
    endfunction

    function automatic t_result make_event(t_event ev, int pos, logic [7:0] data, int cnt);
        t_result r;
        r.event_res = ev;
        r.position  = pos[IDX_W-1:0];
        r.data_byte = data;
        r.arg_count = cnt[ARG_W-1:0];
        return r;
    endfunction

    function automatic t_result tokenize_byte(logic [7:0] b);
        int     lim;
        int     arg_lim;
        int     cnt;
        int     pos;
        t_event ev;
        lim     = (buf_size_reg > BUF_DEPTH) ? BUF_DEPTH : buf_size_reg;
        arg_lim = (max_args_reg > MAX_ARGS) ? MAX_ARGS : max_args_reg;

        if (!line_active) begin
            if (b == CH_PLUS || b == CH_MINUS || b == CH_COLON || b == CH_DOLLAR ||
                b == CH_STAR || b == CH_CR || b == CH_LF)
                return make_event(EV_IGNORED, 0, 8'h00, tokens);
            if (fill_pos != 0) begin
                cnt = tokens;
                clear_line();
                return make_event(EV_SYNTAX, 0, 8'h00, cnt);
            end
            line_active = 1'b1;
        end

        if (b == CH_CR || b == CH_LF) begin
            if (fill_pos == 0) begin
                cnt = tokens;
                clear_line();
                return make_event(EV_EMPTY, 0, 8'h00, cnt);
            end
            // close the open token, or back out a trailing separator
            if (token_base != fill_pos)
                bump_tokens();
            else
                fill_pos--;
            cnt = tokens;
            pos = fill_pos;
            clear_line();
            if (cnt > arg_lim)
                return make_event(EV_ARGS, 0, 8'h00, cnt);
            if (pos >= lim)
                return make_event(EV_OVERFLOW, 0, 8'h00, cnt);
            return make_event(EV_DONE, pos, 8'h00, cnt);
        end

        if (b == CH_SPACE) begin
            if (token_base == fill_pos)
                return make_event(EV_EXTRA_SPACE, 0, 8'h00, tokens);
            if (fill_pos < lim) begin
                pos = fill_pos;
                fill_pos++;
                ev = EV_SEP;
            end else begin
                pos = 0;
                ev = EV_SEP_UNSTORED;
            end
            bump_tokens();
            token_base = fill_pos;
            return make_event(ev, pos, 8'h00, tokens);
        end

        if (fill_pos < lim) begin
            pos = fill_pos;
            fill_pos++;
            return make_event(EV_STORED, pos, b, tokens);
        end
        return make_event(EV_FULL, 0, 8'h00, tokens);
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            fails++;
            $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_line();
            buf_size_reg = BUF_DEPTH;
            max_args_reg = MAX_ARGS;
            line_events.delete();
        end else begin
            // retire the output beat first: it can never belong to this edge's input
            if (i_out_valid && i_out_ready) begin
                if (line_events.size() == 0) begin
                    fails++;
                    $display("%0t ns: event expected none actual %0d", $time, i_event_res);
                end else begin
                    want_ev = line_events.pop_front();
                    check_field("event_res", want_ev.event_res, i_event_res);
                    check_field("position",  want_ev.position,  i_position);
                    check_field("data_byte", want_ev.data_byte, i_data_byte);
                    check_field("arg_count", want_ev.arg_count, i_arg_count);
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_IDX_SIZE)
                    buf_size_reg = i_cfg_data[CFG_SIZE_W-1:0];
                else
                    max_args_reg = i_cfg_data[CFG_ARGS_W-1:0];
            end
            if (i_in_valid && i_in_ready)
                line_events.push_back(tokenize_byte(i_in_byte));
        end
        o_fail_count <= fails;
        o_pending    <= line_events.size();
    end

endmodule

>>> tb/sv/inline_command_line_tokenizer_tb.sv
`timescale 1ns / 1ps
// Top of the line tokenizer testbench: clock, reset, byte and register stimulus,
// output stalls and verdict. Depends on icl_pkg, icl_tokenizer_monitor and the RTL.
module inline_command_line_tokenizer_tb;
    import icl_pkg::*;

    localparam int LIMIT       = 300000;  // cycles before the run is called hung
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 12;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    logic [7:0]            i_in_byte   = 8'h00;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [3:0]            o_event_res;
    logic [8:0]            o_position;
    logic [7:0]            o_data_byte;
    logic [4:0]            o_arg_count;
    logic                  i_cfg_we    = 1'b0;
    logic                  i_cfg_index = CFG_IDX_SIZE;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    int fail_count;
    int pending;
    int items_sent  = 0;
    int cycle_count = 0;
    bit idle_enabled = 1'b1;

    // register settings per random phase; the last one runs without idling
    int phase_size [PHASES] = '{2, 8, 0, 16, 300, 40, 5, 1, 256, 64};
    int phase_args [PHASES] = '{3, 1, 16, 0, 31, 5, 2, 17, 8, 16};

    inline_command_line_tokenizer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_byte   (i_in_byte),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_event_res (o_event_res),
        .o_position  (o_position),
        .o_data_byte (o_data_byte),
        .o_arg_count (o_arg_count),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    icl_tokenizer_monitor token_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_byte    (i_in_byte),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_event_res  (o_event_res),
        .i_position   (o_position),
        .i_data_byte  (o_data_byte),
        .i_arg_count  (o_arg_count),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog: a healthy run ends far below this even with every gap and
    // stall at its longest.
    initial begin
        while (cycle_count < LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[inline_command_line_tokenizer] ERROR");
        $finish;
    end

    // Output side: random stall bursts between stretches of steady ready, none
    // when idling is off. Each pass makes one assignment, then waits for edges.
    initial begin
        int n;
        forever begin
            if (idle_enabled && $urandom_range(0, 2) == 0) begin
                i_out_ready <= 1'b0;
                n = $urandom_range(1, 15);
            end else begin
                i_out_ready <= 1'b1;
                n = $urandom_range(1, 30);
            end
            repeat (n) @(posedge i_clk);
        end
    end

    // Push one byte beat. Sometimes drop valid for a burst first; otherwise
    // keep valid high so beats go back to back. Return at the accepting edge.
    task automatic send_byte(logic [7:0] b, bit counted);
        if (idle_enabled && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        if (counted)
            items_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b1);
    endtask

    // Drop valid and wait until every predicted event has been seen, plus the
    // two-stage pipeline depth and some margin, so a register write cannot
    // overtake a byte still inside the block.
    task automatic settle();
        i_in_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic set_config(int size, int args);
        settle();
        write_reg(CFG_IDX_SIZE, size[CFG_DATA_W-1:0]);
        write_reg(CFG_IDX_ARGS, args[CFG_DATA_W-1:0]);
    endtask

    function automatic logic [7:0] prefix_byte();
        case ($urandom_range(0, 6))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_COLON;
            3:       return CH_DOLLAR;
            4:       return CH_STAR;
            5:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    // Token content: mostly printable, sometimes any byte but the delimiters.
    function automatic logic [7:0] token_char();
        logic [7:0] c;
        if ($urandom_range(0, 3) != 0)
            return 8'($urandom_range(8'h21, 8'h7E));
        do c = 8'($urandom_range(0, 255));
        while (c == CH_SPACE || c == CH_CR || c == CH_LF);
        return c;
    endfunction

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 5))
            0:       return CH_SPACE;
            1:       return $urandom_range(0, 1) ? CH_CR : CH_LF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Well-formed line with random content: idle prefix, optional leading and
    // trailing spaces, runs of spaces between tokens, CR or LF, maybe another LF.
    task automatic send_random_line();
        int n_tok;
        int len;
        repeat ($urandom_range(0, 2)) send_byte(prefix_byte(), 1'b0);
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 2)) send_byte(CH_SPACE, 1'b1);
        n_tok = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 4);
        for (int i = 0; i < n_tok; i++) begin
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
            repeat (len) send_byte(token_char(), 1'b1);
            if (i < n_tok - 1)
                repeat (($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1)
                    send_byte(CH_SPACE, 1'b1);
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) send_byte(CH_SPACE, 1'b1);
        send_byte($urandom_range(0, 1) ? CH_CR : CH_LF, 1'b1);
        if ($urandom_range(0, 3) == 0)
            send_byte(CH_LF, 1'b0);
    endtask

    initial begin
        int target;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset settings: idle prefix bytes are ignored, a lone
        // space then CR is an empty line, doubled spaces drop, a trailing
        // space is undone at line end, and the byte extremes store.
        send_byte(CH_PLUS, 1'b0);
        send_byte(CH_MINUS, 1'b0);
        send_byte(CH_COLON, 1'b0);
        send_byte(CH_DOLLAR, 1'b0);
        send_byte(CH_STAR, 1'b0);
        send_byte(CH_CR, 1'b0);
        send_byte(CH_LF, 1'b0);
        send_text(" \r");
        send_text("a  b \n");
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(CH_SPACE, 1'b1);
        send_byte(8'h80, 1'b1);
        send_byte(CH_LF, 1'b1);

        // One-byte buffer: too many tokens, then a separator that no longer
        // fits, then an overflow at line end.
        set_config(1, 0);
        send_text("a\n");
        set_config(1, 16);
        send_text("ab c\n");
        send_text("ab\n");

        // Oversized register values clamp to the build limits: fill the full
        // depth and run past it, then a line that ends on the last slot.
        set_config(511, 31);
        repeat (258) send_byte(token_char(), 1'b1);
        send_byte(CH_LF, 1'b1);
        repeat (255) send_byte(token_char(), 1'b1);
        send_byte(CH_LF, 1'b1);

        // Random phases: mostly well-formed lines, some raw noise. Each phase
        // ends on LF so the block is back to idle before the next write.
        for (int p = 0; p < PHASES; p++) begin
            idle_enabled = (p != PHASES - 1);
            if (p == 6)
                set_config($urandom_range(1, 511), $urandom_range(0, 31));
            else
                set_config(phase_size[p], phase_args[p]);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 10)) send_byte(noise_byte(), 1'b1);
                else
                    send_random_line();
            end
            send_byte(CH_LF, 1'b1);
        end

        settle();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("[inline_command_line_tokenizer] OK");
        else
            $display("[inline_command_line_tokenizer] ERROR");
        $finish;
    end

endmodule
